// File: sv/bec_pkg.sv
// Package for the backslash escape codec: word types, register indexes
// and character constants. No dependencies.
`default_nettype none

package bec_pkg;

	localparam int unsigned CFG_W       = 11;
	localparam int unsigned LIMIT_MAX   = (2 ** CFG_W) - 1;
	localparam int unsigned MAX_OUT_DEF = 1024;
	localparam logic [CFG_W-1:0] LIMIT_RESET = CFG_W'(1024);

	// Configuration register indexes
	localparam logic REG_DECODE_MODE  = 1'b0;
	localparam logic REG_OUTPUT_LIMIT = 1'b1;

	localparam logic [7:0] BSLASH    = 8'h5C;
	localparam logic [7:0] ZERO_CHAR = 8'h30;
	localparam logic [7:0] NUL       = 8'h00;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       buffer_end;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
	} out_t;

	// Up to two bytes produced by one input word
	typedef struct packed {
		logic [1:0] n;
		logic [7:0] b0;
		logic [7:0] b1;
	} res_t;

endpackage

`default_nettype wire

// File: sv/bec_chan_if.sv
// Valid/ready channel carrying one word of payload type T.
// Used with the word types of bec_pkg.
`default_nettype none

interface bec_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: sv/bec_step.sv
// Conversion step of the codec: encodes or decodes one buffered word and
// keeps the decode state (pending backslash, stopped, byte count). Uses bec_pkg.
`default_nettype none

module bec_step #(
	parameter int MAX_OUT = bec_pkg::MAX_OUT_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         fire,
	input  wire                         mode,
	input  wire [bec_pkg::CFG_W-1:0]    limit,
	input  bec_pkg::in_t                word,
	output bec_pkg::res_t               res
);
	import bec_pkg::*;

	localparam int LIM_MAX = (MAX_OUT < int'(LIMIT_MAX)) ? MAX_OUT : int'(LIMIT_MAX);
	localparam int CNT_W   = $clog2(LIM_MAX + 1);

	typedef struct packed {
		logic             ok;
		logic             stop;
		logic [CNT_W-1:0] cnt;
	} emit_t;

	function automatic emit_t emit_one(input logic s, input logic [CNT_W-1:0] c,
			input logic [CNT_W-1:0] l);
		emit_t r;
		r.ok   = 1'b0;
		r.stop = s;
		r.cnt  = c;
		if (!s) begin
			if (c < l) begin
				r.ok  = 1'b1;
				r.cnt = c + 1'b1;
			end
			if (r.cnt >= l) begin
				r.stop = 1'b1;
			end
		end
		return r;
	endfunction

	logic             pend_q, stop_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pend_d, stop_d;
	logic [CNT_W-1:0] cnt_d;
	logic [CNT_W-1:0] lim;
	logic             try1, try2, plain2;
	logic [7:0]       x1, x2;
	emit_t            e1, e2;
	logic             ok2;
	logic [7:0]       b;
	logic             last;

	assign b    = word.in_byte;
	assign last = word.buffer_end;
	assign lim  = (32'(limit) > MAX_OUT) ? CNT_W'(MAX_OUT) : CNT_W'(limit);

	always_comb begin
		pend_d = pend_q;
		stop_d = stop_q;
		cnt_d  = cnt_q;
		try1   = 1'b0;
		try2   = 1'b0;
		plain2 = 1'b0;
		x1     = b;
		x2     = b;
		ok2    = 1'b0;
		e1     = '0;
		e2     = '0;
		res    = '0;
		if (!mode) begin
			if (b == NUL) begin
				res = '{n: 2'd2, b0: BSLASH, b1: ZERO_CHAR};
			end else if (b == BSLASH) begin
				res = '{n: 2'd2, b0: BSLASH, b1: BSLASH};
			end else begin
				res = '{n: 2'd1, b0: b, b1: b};
			end
		end else begin
			if (!stop_q) begin
				if (pend_q) begin
					pend_d = 1'b0;
					try1   = 1'b1;
					if (b == ZERO_CHAR) begin
						x1 = NUL;
					end else if (b == BSLASH) begin
						x1 = BSLASH;
					end else begin
						// Unpaired backslash is literal; the new byte follows.
						x1     = BSLASH;
						try2   = last;
						plain2 = !last;
					end
				end else if (last) begin
					try1 = 1'b1;
				end else begin
					plain2 = 1'b1;
				end
			end
			e1 = emit_one(stop_q, cnt_q, lim);
			if (try1) begin
				stop_d = e1.stop;
				cnt_d  = e1.cnt;
			end
			e2 = emit_one(stop_d, cnt_d, lim);
			if (try2) begin
				ok2    = e2.ok;
				stop_d = e2.stop;
				cnt_d  = e2.cnt;
			end else if (plain2 && !stop_d) begin
				if (b == BSLASH) begin
					pend_d = 1'b1;
				end else if (b == NUL) begin
					stop_d = 1'b1;
				end else begin
					ok2    = e2.ok;
					stop_d = e2.stop;
					cnt_d  = e2.cnt;
				end
			end
			if (stop_d) begin
				pend_d = 1'b0;
			end
			if (last) begin
				pend_d = 1'b0;
				stop_d = 1'b0;
				cnt_d  = '0;
			end
			res.n  = 2'({1'b0, try1 & e1.ok} + {1'b0, ok2});
			res.b0 = (try1 && e1.ok) ? x1 : x2;
			res.b1 = x2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			stop_q <= 1'b0;
			cnt_q  <= '0;
		end else if (fire && mode) begin
			pend_q <= pend_d;
			stop_q <= stop_d;
			cnt_q  <= cnt_d;
		end
	end

endmodule

`default_nettype wire

// File: sv/bec_obuf.sv
// Codec's two-byte output register: loads the bytes of one word and sends
// them one per cycle while result is ready. Uses bec_pkg, bec_chan_if.
`default_nettype none

module bec_obuf (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             load,
	input  bec_pkg::res_t   res,
	output logic            free,
	bec_chan_if.source      result
);
	import bec_pkg::*;

	logic [1:0] cnt_q;
	logic [7:0] slot0_q, slot1_q;
	logic       take;

	assign take         = result.valid && result.ready;
	assign free         = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && result.ready);
	assign result.valid = (cnt_q != 2'd0);
	assign result.data  = '{out_byte: slot0_q, run_last: (cnt_q == 2'd1)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= res.n;
		end else if (take) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot0_q <= res.b0;
			slot1_q <= res.b1;
		end else if (take) begin
			slot0_q <= slot1_q;
		end
	end

endmodule

`default_nettype wire

// File: sv/backslash_escape_codec.sv
// Top level of the backslash escape codec. Depends on bec_pkg, bec_chan_if,
// bec_step and bec_obuf.
//
// A word taken on the item channel is held in an input register, converted
// combinationally and loaded into a two-byte output register once that
// register is free. A word that gives two bytes (encode of a zero or a
// backslash, decode of a lone backslash followed by another byte) stays
// longer in the output register, which sends one byte per cycle while the
// result channel is ready. A new word is accepted while earlier bytes still
// wait on the result channel. There is no memory and no clearing pass after
// reset. Configuration is written through cfg_we/cfg_index/cfg_data:
// index 0 is decode_mode, index 1 is output_limit.
`default_nettype none

module backslash_escape_codec #(
	parameter int MAX_OUT = bec_pkg::MAX_OUT_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_we,
	input  wire                         cfg_index,
	input  wire [bec_pkg::CFG_W-1:0]    cfg_data,
	bec_chan_if.sink                    item,
	bec_chan_if.source                  result
);
	import bec_pkg::*;

	logic             mode_q;
	logic [CFG_W-1:0] limit_q;
	logic             valid_s1;
	in_t              item_s1;
	logic             free;
	logic             adv;
	res_t             res;

	assign adv        = valid_s1 && free;
	assign item.ready = !valid_s1 || free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b0;
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DECODE_MODE:  mode_q  <= cfg_data[0];
				REG_OUTPUT_LIMIT: limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= item.data;
		end
	end

	bec_step #(
		.MAX_OUT (MAX_OUT)
	) u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (adv),
		.mode   (mode_q),
		.limit  (limit_q),
		.word   (item_s1),
		.res    (res)
	);

	bec_obuf u_obuf (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (adv),
		.res    (res),
		.free   (free),
		.result (result)
	);

`ifndef ASSERT_OFF
	// Encoding never drops a byte.
	a_encode_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !mode_q) |-> (res.n != 2'd0))
		else $error("encode word produced no byte");

	// One word never gives more than two bytes.
	a_two_max: assert property (@(posedge clk) disable iff (!arst_n)
		adv |-> (res.n != 2'd3))
		else $error("word produced more than two bytes");

	// A held word stays put until the output register can take it.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !free) |=> (valid_s1 && $stable(item_s1)))
		else $error("input register changed while blocked");
`endif

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// Self-checking bench for backslash_escape_codec: drives random and directed
// words in both modes and checks every result word against its own predictor.
// Depends on bec_pkg, bec_chan_if and backslash_escape_codec from the RTL.

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bec_pkg::*;

	localparam int CODEC_MAX_OUT = MAX_OUT_DEF;
	localparam int IDLE_MAX      = 18;
	localparam int DRAIN_CYCLES  = 6;
	localparam int RUN_LIMIT     = 400000;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic                cfg_index;
	logic [CFG_W-1:0]    cfg_data;

	bec_chan_if #(.T(in_t))  item_if ();
	bec_chan_if #(.T(out_t)) result_if ();

	backslash_escape_codec #(
		.MAX_OUT (CODEC_MAX_OUT)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item_if),
		.result    (result_if)
	);

	// Predictor state and configuration
	logic              dec_mode   = 1'b0;
	logic [CFG_W-1:0]  lim_reg    = LIMIT_RESET;
	logic              esc_pend   = 1'b0;
	logic              halted     = 1'b0;
	logic [CFG_W-1:0]  out_count  = '0;
	logic [7:0]        step_bytes[$];
	out_t              expected_bytes[$];
	out_t              head_word;

	int fail_count  = 0;
	int items_sent  = 0;
	int cycle_count = 0;
	int snd_max     = IDLE_MAX;
	int rcv_max     = IDLE_MAX;
	int hold_cycles = 0;

	always #1 clk = ~clk;

	function automatic int draw_wait(input int top);
		if ($urandom_range(0, 1) == 0)
			return $urandom_range(0, top);
		return 0;
	endfunction

	function automatic void emit_capped(input logic [7:0] b);
		int cap;
		cap = (lim_reg > CODEC_MAX_OUT) ? CODEC_MAX_OUT : int'(lim_reg);
		if (!halted) begin
			if (out_count < cap) begin
				step_bytes.push_back(b);
				out_count++;
			end
			if (out_count >= cap)
				halted = 1'b1;
		end
	endfunction

	function automatic void take_plain(input logic [7:0] b);
		if (!halted) begin
			if (b == BSLASH)
				esc_pend = 1'b1;
			else if (b == NUL)
				halted = 1'b1;
			else
				emit_capped(b);
		end
	endfunction

	// Works out the result words that one accepted word causes.
	function automatic void convert_word(input in_t w);
		out_t e;
		step_bytes.delete();
		if (!dec_mode) begin
			if (w.in_byte == NUL) begin
				step_bytes.push_back(BSLASH);
				step_bytes.push_back(ZERO_CHAR);
			end else if (w.in_byte == BSLASH) begin
				step_bytes.push_back(BSLASH);
				step_bytes.push_back(BSLASH);
			end else begin
				step_bytes.push_back(w.in_byte);
			end
		end else begin
			if (!halted) begin
				if (esc_pend) begin
					esc_pend = 1'b0;
					if (w.in_byte == ZERO_CHAR) begin
						emit_capped(NUL);
					end else if (w.in_byte == BSLASH) begin
						emit_capped(BSLASH);
					end else begin
						// A lone backslash is kept, then the new byte goes its usual way.
						emit_capped(BSLASH);
						if (w.buffer_end)
							emit_capped(w.in_byte);
						else
							take_plain(w.in_byte);
					end
				end else if (w.buffer_end) begin
					emit_capped(w.in_byte);
				end else begin
					take_plain(w.in_byte);
				end
			end
			if (halted)
				esc_pend = 1'b0;
			if (w.buffer_end) begin
				esc_pend  = 1'b0;
				halted    = 1'b0;
				out_count = '0;
			end
		end
		foreach (step_bytes[k]) begin
			e.out_byte = step_bytes[k];
			e.run_last = (k == step_bytes.size() - 1);
			expected_bytes.push_back(e);
		end
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_if.valid && item_if.ready)
				convert_word(item_if.data);
			if (result_if.valid && result_if.ready) begin
				if (expected_bytes.size() == 0) begin
					report_mismatch("unexpected word", result_if.data.out_byte, 0);
				end else begin
					head_word = expected_bytes.pop_front();
					if (result_if.data.out_byte !== head_word.out_byte)
						report_mismatch("out_byte", result_if.data.out_byte, head_word.out_byte);
					if (result_if.data.run_last !== head_word.run_last)
						report_mismatch("run_last", result_if.data.run_last, head_word.run_last);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Result side: random stalls per word, plus a long hold-off on request.
	initial begin
		int n;
		result_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_cycles > 0) begin
				result_if.ready <= 1'b0;
				repeat (hold_cycles) @(negedge clk);
				hold_cycles = 0;
			end
			n = draw_wait(rcv_max);
			if (n > 0) begin
				result_if.ready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			result_if.ready <= 1'b1;
			do @(posedge clk); while (!(result_if.valid === 1'b1 && result_if.ready));
			@(negedge clk);
		end
	end

	// Offers one word after a random gap and returns once it has been taken.
	task automatic send_word(input logic [7:0] b, input logic last);
		int gap;
		in_t w;
		gap = draw_wait(snd_max);
		w.in_byte    = b;
		w.buffer_end = last;
		@(negedge clk);
		if (gap > 0) begin
			item_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_if.data  <= w;
		item_if.valid <= 1'b1;
		do @(posedge clk); while (!item_if.ready);
		items_sent++;
	endtask

	// Words that give no result may still be in flight, hence the pause.
	task automatic wait_drained();
		@(negedge clk);
		item_if.valid <= 1'b0;
		while (expected_bytes.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		if (idx == REG_DECODE_MODE)
			dec_mode = value[0];
		else
			lim_reg = value;
	endtask

	// Only bit 0 selects the mode; the upper bits are filled at random.
	task automatic set_mode(input logic m);
		write_reg(REG_DECODE_MODE, {10'($urandom), m});
	endtask

	// One buffer of well-formed escapes mixed with stray and raw bytes.
	task automatic send_buffer(input int len);
		int i;
		logic [7:0] b;
		for (i = 0; i < len; i++) begin
			b = 8'($urandom_range(1, 255));
			if (b == BSLASH)
				b = 8'h5B;
			case ($urandom_range(0, 19))
				0, 1, 2: begin
					send_word(BSLASH, 1'b0);
					b = ZERO_CHAR;
				end
				3, 4, 5: begin
					send_word(BSLASH, 1'b0);
					b = BSLASH;
				end
				6, 7: begin
					send_word(BSLASH, 1'b0);
				end
				8: b = NUL;
				9, 10: b = 8'($urandom);
				11: b = ZERO_CHAR;
				default: ;
			endcase
			send_word(b, i == len - 1);
		end
	endtask

	task automatic test_encode_extremes();
		set_mode(1'b0);
		send_word(NUL, 1'b1);
		send_word(BSLASH, 1'b0);
		send_word(ZERO_CHAR, 1'b0);
		send_word(8'hFF, 1'b1);
	endtask

	task automatic test_decode_escapes();
		wait_drained();
		write_reg(REG_OUTPUT_LIMIT, LIMIT_RESET);
		set_mode(1'b1);
		send_word(BSLASH, 1'b0);
		send_word(ZERO_CHAR, 1'b0);
		send_word(BSLASH, 1'b0);
		send_word(BSLASH, 1'b0);
		send_word(BSLASH, 1'b0);
		send_word(8'h41, 1'b0);
		// A pending backslash pairs with the final byte.
		send_word(BSLASH, 1'b0);
		send_word(BSLASH, 1'b1);
		// A raw zero stops the buffer until its end.
		send_word(8'h41, 1'b0);
		send_word(NUL, 1'b0);
		send_word(8'h42, 1'b0);
		send_word(8'h43, 1'b1);
		// Final bytes are copied as they are.
		send_word(NUL, 1'b1);
		send_word(BSLASH, 1'b1);
		send_word(BSLASH, 1'b0);
		send_word(8'h31, 1'b1);
	endtask

	task automatic test_decode_limits();
		wait_drained();
		write_reg(REG_OUTPUT_LIMIT, 11'd3);
		send_word(8'h41, 1'b0);
		send_word(BSLASH, 1'b0);
		send_word(ZERO_CHAR, 1'b0);
		send_word(8'h42, 1'b1);
		wait_drained();
		write_reg(REG_OUTPUT_LIMIT, 11'd1);
		send_word(BSLASH, 1'b0);
		send_word(8'h41, 1'b1);
		wait_drained();
		write_reg(REG_OUTPUT_LIMIT, 11'd0);
		send_word(8'h41, 1'b1);
	endtask

	task automatic test_mode_switch();
		wait_drained();
		write_reg(REG_OUTPUT_LIMIT, LIMIT_RESET);
		send_word(BSLASH, 1'b0);
		wait_drained();
		set_mode(1'b0);
		send_word(8'h41, 1'b0);
		wait_drained();
		set_mode(1'b1);
		send_word(ZERO_CHAR, 1'b1);
	endtask

	task automatic test_random_encode();
		int n;
		logic [7:0] b;
		wait_drained();
		set_mode(1'b0);
		for (n = 0; n < 120; n++) begin
			case ($urandom_range(0, 3))
				0: b = NUL;
				1: b = BSLASH;
				default: b = 8'($urandom);
			endcase
			send_word(b, 1'($urandom));
		end
	endtask

	// Long hold on the result side while words keep coming back to back.
	task automatic test_stall_fill();
		int n;
		wait_drained();
		set_mode(1'b0);
		snd_max     = 0;
		hold_cycles = 150;
		for (n = 0; n < 40; n++)
			send_word((n % 3 == 0) ? 8'($urandom) : (n[0] ? BSLASH : NUL), 1'b0);
		wait_drained();
		snd_max = IDLE_MAX;
	endtask

	task automatic test_random_decode();
		int phase;
		int start;
		logic [CFG_W-1:0] lim;
		for (phase = 0; phase < 7; phase++) begin
			wait_drained();
			case (phase)
				0: lim = LIMIT_RESET;
				1: lim = 11'h7FF;
				2: lim = 11'd1;
				3: lim = 11'd0;
				4: lim = 11'($urandom_range(2, 8));
				5: lim = 11'($urandom_range(0, 2047));
				default: lim = 11'($urandom_range(9, 40));
			endcase
			write_reg(REG_OUTPUT_LIMIT, lim);
			set_mode(1'b1);
			snd_max = (phase == 1 || phase == 5) ? 0 : IDLE_MAX;
			rcv_max = snd_max;
			start = items_sent;
			while (items_sent - start < 65)
				send_buffer($urandom_range(1, 12));
		end
		snd_max = IDLE_MAX;
		rcv_max = IDLE_MAX;
	endtask

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_DECODE_MODE;
		cfg_data      = '0;
		item_if.valid = 1'b0;
		item_if.data  = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_encode_extremes();
		test_decode_escapes();
		test_decode_limits();
		test_mode_switch();
		test_random_encode();
		test_stall_fill();
		test_random_decode();

		wait_drained();
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
